@@ hdl/srre_pkg.sv @@
// Shared types and constants of the sprite row run-length encoder.
package srre_pkg;

    localparam int CFG_W     = 13;
    localparam int ROW_LIMIT = 4096;
    localparam int ROW_W     = 13;

    localparam logic [7:0] TRANS_CODE = 8'h80;
    localparam logic [6:0] RUN_MASK   = 7'h7f;

    localparam logic [3:0] FULL_COUNT = 4'd8;

    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CLOSE_HDR,
        ST_CLOSE_DATA,
        ST_ROW_END
    } t_state;

endpackage

@@ hdl/sprite_row_rle_encoder.sv @@
// Top level of the sprite row run-length encoder: sequencer, run buffer and byte packer.
//
//  Channel   Direction  Handshake                    Payload
//  --------  ---------  ---------------------------  -----------------------------------------
//  in        sink       i_in_valid / o_in_stall      i_pixel[7:0]
//  out       source     o_out_valid / i_out_stall    o_out_word[63:0], o_byte_count[3:0],
//                                                    o_frame_done
//  cfg       sink       i_cfg_we                     i_cfg_index (0 row_width, 1 row_count),
//                                                    i_cfg_data[12:0]
//
//  A pixel that closes nothing passes through the idle and add steps; a pixel that closes a run
//  or a row also produces encoded bytes: a run header, one for each buffered opaque pixel, and
//  the row-end mark. All bytes pass one at a time through the single byte packer.
//  Reset is synchronous and active low; it clears the run, the indexes and the packer.
//  A stalled output holds a completed word; the packer then waits only when it must emit.
//
module sprite_row_rle_encoder
    import srre_pkg::*;
#(
    parameter int MAX_RUN   = 127,
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input transaction
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_pixel,
    // encoded word output transaction
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [63:0]       o_out_word,
    output logic [3:0]        o_byte_count,
    output logic              o_frame_done,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // Widths that follow from the parameters. The run length must hold MAX_RUN itself,
    // and the column index must hold MAX_WIDTH.
    localparam int LW   = $clog2(MAX_RUN + 1);
    localparam int AW   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;

    // Configuration registers.
    logic [CFG_W-1:0] r_row_width;
    logic [CFG_W-1:0] r_row_count;

    // Sequencer state and the state to resume after a run has been closed.
    t_state r_state, n_state;
    t_state r_ret;

    // Run state.
    logic [LW-1:0] r_len;
    logic          r_trans;
    logic [7:0]    r_pix;
    logic          r_pix_t;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Run buffer: written while a run grows, read back one byte a cycle when it closes, unless the packer holds a push.
    logic [7:0]    run_mem [MAX_RUN];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // Byte packer and output register.
    logic [55:0] r_pack;
    logic [2:0]  r_fill;
    logic        r_o_valid;
    logic [63:0] r_o_word;
    logic [3:0]  r_o_count;
    logic        r_o_done;

    // Effective frame geometry after clamping the registers to their legal ranges.
    logic [CMPW-1:0] w_eff;
    logic [ROW_W:0]  h_eff;

    always_comb begin
        if (r_row_width == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_row_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_row_width);
        end
        if (r_row_count == '0) begin
            h_eff = (ROW_W + 1)'(1);
        end else if ((ROW_W + 1)'(r_row_count) > (ROW_W + 1)'(ROW_LIMIT)) begin
            h_eff = (ROW_W + 1)'(ROW_LIMIT);
        end else begin
            h_eff = (ROW_W + 1)'(r_row_count);
        end
    end

    // Values the pixel leaves behind in the add step.
    logic          add_trans;
    logic [LW-1:0] add_len;
    logic [CW-1:0] col_nxt;
    logic          row_end;
    logic          run_full;
    logic [ROW_W-1:0] row_nxt;
    logic          frame_end;

    assign add_trans = (r_len == '0) ? r_pix_t : r_trans;
    assign add_len   = r_len + LW'(1);
    assign col_nxt   = r_col + CW'(1);
    assign row_end   = CMPW'(col_nxt) >= w_eff;
    assign run_full  = add_len >= LW'(MAX_RUN);
    assign row_nxt   = r_row + ROW_W'(1);
    assign frame_end = (ROW_W + 1)'(row_nxt) >= h_eff;

    // Byte push into the packer. A push that completes a word, or the last byte of a frame,
    // needs the output register to be free.
    logic        can_emit;
    logic        push_req;
    logic        push_final;
    logic [7:0]  push_byte;
    logic        push_ok;
    logic        emit;
    logic        last_data;
    logic [63:0] merged;

    assign can_emit  = !r_o_valid || !i_out_stall;
    assign last_data = LW'(r_idx) == (r_len - LW'(1));

    // Output decode of the sequencer.
    always_comb begin
        push_req   = 1'b0;
        push_final = 1'b0;
        push_byte  = 8'h00;
        case (r_state)
            ST_CLOSE_HDR: begin
                push_req  = 1'b1;
                push_byte = r_trans ? (TRANS_CODE | 8'({RUN_MASK & 7'(r_len)}))
                                    : 8'({RUN_MASK & 7'(r_len)});
            end
            ST_CLOSE_DATA: begin
                push_req  = 1'b1;
                push_byte = r_rd_data;
            end
            ST_ROW_END: begin
                push_req   = 1'b1;
                push_final = frame_end;
                push_byte  = TRANS_CODE;
            end
            default: begin
                push_req = 1'b0;
            end
        endcase
    end

    assign push_ok = push_req && (((r_fill == 3'd7) || push_final) ? can_emit : 1'b1);
    assign emit    = push_ok && ((r_fill == 3'd7) || push_final);
    assign merged  = {8'h00, r_pack} | (64'(push_byte) << {r_fill, 3'b000});

    // Next-state decode of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if ((r_len != '0) && ((i_pixel == 8'h00) != r_trans)) begin
                        n_state = ST_CLOSE_HDR;
                    end else begin
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                if (row_end) begin
                    n_state = add_trans ? ST_ROW_END : ST_CLOSE_HDR;
                end else if (run_full) begin
                    n_state = ST_CLOSE_HDR;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLOSE_HDR: begin
                if (push_ok) begin
                    n_state = r_trans ? r_ret : ST_CLOSE_DATA;
                end
            end
            ST_CLOSE_DATA: begin
                if (push_ok && last_data) begin
                    n_state = r_ret;
                end
            end
            ST_ROW_END: begin
                if (push_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The input is held off during reset so that no pixel is taken and then lost.
    assign o_in_stall = (r_state != ST_IDLE) || !i_rst_n;

    // Read address of the run buffer. The header cycle fetches the first byte; each
    // accepted data byte fetches the next one, and a held push re-reads the same entry.
    always_comb begin
        logic [LW-1:0] idx_inc;
        idx_inc = LW'(r_idx) + LW'(1);
        if (r_state == ST_CLOSE_DATA) begin
            if (push_ok && (idx_inc < LW'(MAX_RUN))) begin
                rd_addr = AW'(idx_inc);
            end else if (push_ok) begin
                rd_addr = '0;
            end else begin
                rd_addr = r_idx;
            end
        end else begin
            rd_addr = '0;
        end
    end

    assign mem_we = (r_state == ST_ADD) && !r_pix_t && (r_len < LW'(MAX_RUN));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            run_mem[AW'(r_len)] <= r_pix;
        end
        r_rd_data <= run_mem[rd_addr];
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= CFG_W'(1);
            r_row_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ROW_WIDTH) begin
                r_row_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_ROW_COUNT) begin
                r_row_count <= i_cfg_data;
            end
        end
    end

    // Sequencer and run bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_len   <= '0;
            r_trans <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_ret <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_trans <= add_trans;
                    r_len   <= add_len;
                    r_col   <= col_nxt;
                    if (row_end) begin
                        r_ret <= ST_ROW_END;
                        if (add_trans) begin
                            r_len <= '0;
                        end
                    end else if (run_full) begin
                        r_ret <= ST_IDLE;
                    end
                end
                ST_CLOSE_HDR: begin
                    r_idx <= '0;
                    if (push_ok && r_trans) begin
                        r_len <= '0;
                    end
                end
                ST_CLOSE_DATA: begin
                    if (push_ok) begin
                        r_idx <= r_idx + AW'(1);
                        if (last_data) begin
                            r_len <= '0;
                        end
                    end
                end
                ST_ROW_END: begin
                    if (push_ok) begin
                        r_col <= '0;
                        r_row <= frame_end ? '0 : row_nxt;
                    end
                end
                default: begin
                    r_idx <= '0;
                end
            endcase
        end
    end

    // Incoming pixel capture.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_pix   <= i_pixel;
            r_pix_t <= (i_pixel == 8'h00);
        end
    end

    // Byte packer. The merged value serves all three cases: a partial fill, a full word
    // (seventh lane already filled, new byte in the top lane) and the frame flush.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack <= '0;
            r_fill <= '0;
        end else if (push_ok) begin
            if (emit) begin
                r_pack <= '0;
                r_fill <= '0;
            end else begin
                r_pack <= merged[55:0];
                r_fill <= r_fill + 3'd1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_word  <= merged;
            r_o_count <= 4'({1'b0, r_fill}) + 4'd1;
            r_o_done  <= push_final;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_word   = r_o_word;
    assign o_byte_count = r_o_count;
    assign o_frame_done = r_o_done;

    // A run never grows past its limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_RUN))
        else $error("run length above limit");

    // A full run is always closed before the next pixel is taken.
    a_idle_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_len < LW'(MAX_RUN)))
        else $error("full run left open while idle");

    // Only the flushed word of a frame may be short.
    a_short_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_count != FULL_COUNT)) |-> o_frame_done)
        else $error("short word without frame end");

    // An accepted pixel always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != ST_IDLE))
        else $error("accepted pixel not processed");

endmodule
